[design/dwqs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dwqs_pkg;

   localparam int CAPACITY_DEFAULT = 4096;

   localparam int ACTION_W   = 2;
   localparam int VERTEX_W   = 12;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 13'd4096;

   localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_OFFER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TAKE  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REJECT = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_INIT   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACK_MODE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKWARD_ORDER = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VERTEX_W-1:0] vertex;
      logic                vertex_is_top;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] result_vertex;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  queue_count;
   } rsp_type;

   typedef struct packed {
      logic active;
      logic last;
      logic mark;
   } fill_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

[design/dwqs_fill.sv]
`timescale 1ns / 1ps
`default_nettype none
module dwqs_fill
   import dwqs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [$clog2(CAPACITY+1)-1:0] fill_count,
   input  wire logic                         backward,
   output fill_ctl_type                      ctl,
   output logic [$clog2(CAPACITY)-1:0]       addr,
   output logic [$clog2(CAPACITY)-1:0]       value
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CAPACITY - 1);

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             active_ff;
   logic             active_in;
   logic [CNT_W-1:0] idx_ext;
   logic [CNT_W-1:0] down_value;

   assign idx_ext    = CNT_W'(idx_ff);
   assign down_value = fill_count - CNT_W'(1) - idx_ext;

   always_comb begin
      ctl.active = active_ff;
      ctl.last   = active_ff && (idx_ff == IDX_MAX);
      ctl.mark   = idx_ext < fill_count;
      addr       = idx_ff;
      value      = backward ? IDX_W'(down_value) : idx_ff;
   end

   always_comb begin
      idx_in    = idx_ff;
      active_in = active_ff;
      if (start) begin
         idx_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         idx_in = idx_ff + IDX_W'(1);
         if (idx_ff == IDX_MAX) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

endmodule
`default_nettype wire

[design/dedup_worklist_queue_stack.sv]
// Deduplicated worklist of vertex numbers, FIFO or stack order.
// Input channel req_valid / req_stall / req_data carries one action per
// transaction: init fill, offer a vertex, or take the next vertex. The result
// channel rsp_valid / rsp_stall / rsp_data returns exactly one transaction per
// accepted action, in order. The csr_ port writes vertex_count, stack_mode and
// backward_order; the user must write them only while idle (not enforced by the block).
// Offer, take and unused actions: the action and the ring and bitmap reads are
// registered at acceptance, and in ST_EXEC, once the output register is free,
// the result is registered into rsp_data. req_stall is high from acceptance
// until then, so no new action is taken before the last one executes; this comes
// from the registered read of the ring memory and membership bitmap, then write-back.
// Init: a sweep over all CAPACITY entries, one per cycle, rewrites the bitmap
// and ring entries below vertex_count; the result follows when the output is free.
// Reset empties the worklist (head, tail and count to zero) and restores the
// register defaults; the bitmap holds no meaning until the first init.
// When rsp_stall holds a finished result, the block still accepts the next
// action and completes it once the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module dedup_worklist_queue_stack
   import dwqs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // configuration
   logic [COUNT_W-1:0] vertex_count_ff;
   logic               stack_mode_ff;
   logic               backward_order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff   <= VERTEX_COUNT_RESET;
         stack_mode_ff     <= 1'b0;
         backward_order_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:   vertex_count_ff   <= csr_wdata;
            CSR_STACK_MODE:     stack_mode_ff     <= csr_wdata[0];
            CSR_BACKWARD_ORDER: backward_order_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0] eff_count;
   assign eff_count = (EW'(vertex_count_ff) > EW'(CAPACITY)) ? CAP_CNT
                                                             : CNT_W'(vertex_count_ff);

   // control
   state_type        state_ff;
   state_type        state_in;
   req_type          item_ff;
   logic [IDX_W-1:0] head_ff;
   logic [IDX_W-1:0] head_in;
   logic [IDX_W-1:0] tail_ff;
   logic [IDX_W-1:0] tail_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_in;
   logic             accept;
   logic             exec_en;
   logic             exec_go;
   logic             fill_start;
   fill_ctl_type     fill_ctl;
   logic [IDX_W-1:0] fill_addr;
   logic [IDX_W-1:0] fill_value;
   logic [IDX_W-1:0] tail_dec;
   logic [IDX_W-1:0] tail_inc;
   logic [IDX_W-1:0] head_inc;

   assign accept     = req_valid && !req_stall;
   assign fill_start = accept && (req_data.action == ACT_INIT);
   assign tail_dec   = (tail_ff == '0) ? IDX_MAX : tail_ff - IDX_W'(1);
   assign tail_inc   = (tail_ff == IDX_MAX) ? '0 : tail_ff + IDX_W'(1);
   assign head_inc   = (head_ff == IDX_MAX) ? '0 : head_ff + IDX_W'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.action == ACT_INIT) ? ST_FILL : ST_EXEC;
            end
         end
         ST_FILL: begin
            if (fill_ctl.last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      exec_en   = (state_ff == ST_EXEC);
      exec_go   = exec_en && (!rsp_valid_ff || !rsp_stall);
   end

   dwqs_fill #(
      .CAPACITY (CAPACITY)
   ) u_fill (
      .clock      (clock),
      .reset      (reset),
      .start      (fill_start),
      .fill_count (eff_count),
      .backward   (backward_order_ff),
      .ctl        (fill_ctl),
      .addr       (fill_addr),
      .value      (fill_value)
   );

   // memories
   logic             mark_mem [CAPACITY];
   logic [IDX_W-1:0] ring_mem [CAPACITY];
   logic             mark_rd_ff;
   logic [IDX_W-1:0] ring_rd_ff;
   logic [IDX_W-1:0] mark_raddr;
   logic [IDX_W-1:0] ring_raddr;
   logic             mark_we;
   logic [IDX_W-1:0] mark_waddr;
   logic             mark_wdata;
   logic             ring_we;
   logic [IDX_W-1:0] ring_waddr;
   logic [IDX_W-1:0] ring_wdata;
   logic             x_mark_we;
   logic [IDX_W-1:0] x_mark_addr;
   logic             x_mark_data;
   logic             x_ring_we;

   assign mark_raddr = IDX_W'(req_data.vertex);
   assign ring_raddr = stack_mode_ff ? tail_dec : head_ff;

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (accept) begin
         mark_rd_ff <= mark_mem[mark_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      if (accept) begin
         ring_rd_ff <= ring_mem[ring_raddr];
      end
   end

   // action execution
   always_comb begin
      rsp_in      = '0;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      x_mark_we   = 1'b0;
      x_mark_addr = IDX_W'(item_ff.vertex);
      x_mark_data = 1'b1;
      x_ring_we   = 1'b0;
      rsp_in.status = STAT_OK;
      case (item_ff.action)
         ACT_INIT: begin
            rsp_in.status = STAT_INIT;
            head_in  = '0;
            tail_in  = (eff_count == CAP_CNT) ? '0 : IDX_W'(eff_count);
            count_in = eff_count;
         end
         ACT_OFFER: begin
            if (EW'(item_ff.vertex) >= EW'(eff_count)) begin
               rsp_in.status = STAT_RANGE;
            end else if (mark_rd_ff || item_ff.vertex_is_top || count_ff == CAP_CNT) begin
               rsp_in.status = STAT_REJECT;
            end else begin
               x_mark_we = 1'b1;
               x_ring_we = 1'b1;
               tail_in   = tail_inc;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         ACT_TAKE: begin
            if (count_ff == '0) begin
               rsp_in.status = STAT_EMPTY;
            end else begin
               rsp_in.result_vertex = VERTEX_W'(ring_rd_ff);
               if (stack_mode_ff) begin
                  tail_in = tail_dec;
               end else begin
                  head_in = head_inc;
               end
               count_in    = count_ff - CNT_W'(1);
               x_mark_we   = 1'b1;
               x_mark_addr = ring_rd_ff;
               x_mark_data = 1'b0;
            end
         end
         default: ;
      endcase
      rsp_in.queue_count = COUNT_W'(count_in);
   end

   // write port select: init sweep or item write-back
   always_comb begin
      if (fill_ctl.active) begin
         mark_we    = 1'b1;
         mark_waddr = fill_addr;
         mark_wdata = fill_ctl.mark;
         ring_we    = fill_ctl.mark;
         ring_waddr = fill_addr;
         ring_wdata = fill_value;
      end else begin
         mark_we    = exec_go && x_mark_we;
         mark_waddr = x_mark_addr;
         mark_wdata = x_mark_data;
         ring_we    = exec_go && x_ring_we;
         ring_waddr = tail_ff;
         ring_wdata = IDX_W'(item_ff.vertex);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (exec_go) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
